// ===== rtl/sqltok_pkg.sv =====
// Package for the SQL subset tokenizer: types, token codes, keyword table and helpers.
`timescale 1ns / 1ps
`default_nettype none

package sqltok_pkg;

  localparam int TEXT_LIMIT_DEF = 65536;

  // result queue sizing
  localparam int MAX_RES  = 3;
  localparam int FQ_DEPTH = 4;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

  localparam logic [30:0] INT_MAX = 31'h7FFF_FFFF;
  localparam logic [15:0] SAT16   = 16'hFFFF;

  // token kinds
  localparam logic [4:0] KIND_LPAREN   = 5'd0;
  localparam logic [4:0] KIND_RPAREN   = 5'd1;
  localparam logic [4:0] KIND_COMMA    = 5'd2;
  localparam logic [4:0] KIND_SEMI     = 5'd3;
  localparam logic [4:0] KIND_EQ       = 5'd4;
  localparam logic [4:0] KIND_LT       = 5'd5;
  localparam logic [4:0] KIND_GT       = 5'd6;
  localparam logic [4:0] KIND_STAR     = 5'd7;
  localparam logic [4:0] KIND_STRING   = 5'd8;
  localparam logic [4:0] KIND_INTEGER  = 5'd9;
  localparam logic [4:0] KIND_IDENT    = 5'd10;
  localparam logic [4:0] KIND_KW_FIRST = 5'd11;
  localparam logic [4:0] KIND_INVALID  = 5'd28;
  localparam logic [4:0] KIND_END      = 5'd29;

  localparam int KW_COUNT = 17;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_CHAR   = 2'd1;
  localparam logic [1:0] ERR_STRING = 2'd2;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_DEAD
  } mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_req_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] start_res;
    logic [15:0] length;
    logic [30:0] num_value;
    logic [1:0]  error_code;
    logic [7:0]  bad_char;
    logic        last_of_run;
  } out_req_t;

  // keyword text, right aligned: first character sits in the highest used byte
  function automatic logic [63:0] kw_text(input logic [4:0] idx);
    logic [63:0] txt;
    case (idx)
      5'd0:    txt = 64'("CREATE");
      5'd1:    txt = 64'("DATABASE");
      5'd2:    txt = 64'("DROP");
      5'd3:    txt = 64'("USE");
      5'd4:    txt = 64'("TABLE");
      5'd5:    txt = 64'("SELECT");
      5'd6:    txt = 64'("FROM");
      5'd7:    txt = 64'("WHERE");
      5'd8:    txt = 64'("DELETE");
      5'd9:    txt = 64'("INSERT");
      5'd10:   txt = 64'("INTO");
      5'd11:   txt = 64'("VALUES");
      5'd12:   txt = 64'("UPDATE");
      5'd13:   txt = 64'("SET");
      5'd14:   txt = 64'("PRIMARY");
      5'd15:   txt = 64'("INT");
      5'd16:   txt = 64'("STRING");
      default: txt = '0;
    endcase
    return txt;
  endfunction

  function automatic int kw_len(input logic [4:0] idx);
    int len;
    case (idx)
      5'd0, 5'd5, 5'd8, 5'd9, 5'd11, 5'd12, 5'd16: len = 6;
      5'd1:                                        len = 8;
      5'd2, 5'd6, 5'd10:                           len = 4;
      5'd3, 5'd13, 5'd15:                          len = 3;
      5'd4, 5'd7:                                  len = 5;
      5'd14:                                       len = 7;
      default:                                     len = 0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A]}) ? c - 8'h20 : c;
  endfunction

  // identifier or keyword kind for a buffered word
  function automatic logic [4:0] word_kind(input logic [7:0][7:0] chars,
                                           input logic [15:0] len);
    logic [4:0]  kind;
    logic        hit;
    logic [63:0] txt;
    int          kl;
    kind = KIND_IDENT;
    if (len <= 16'd8) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        txt = kw_text(5'(i));
        kl  = kw_len(5'(i));
        hit = (len == 16'(kl));
        for (int j = 0; j < 8; j++) begin
          if (j < kl && to_upper(chars[j]) != txt[8*(kl-1-j) +: 8]) begin
            hit = 1'b0;
          end
        end
        if (hit) begin
          kind = KIND_KW_FIRST + 5'(i);
        end
      end
    end
    return kind;
  endfunction

  function automatic out_req_t mk_res(input logic [4:0] kind, input logic [15:0] line,
                                      input logic [15:0] col, input logic [15:0] start,
                                      input logic [15:0] len, input logic [30:0] val,
                                      input logic [1:0] err, input logic [7:0] bad);
    out_req_t r;
    r.kind        = kind;
    r.line        = line;
    r.column      = col;
    r.start_res   = start;
    r.length      = len;
    r.num_value   = val;
    r.error_code  = err;
    r.bad_char    = bad;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sql_subset_tokenizer.sv =====
// Top level of the SQL subset tokenizer: input register, lexer step logic, result queue.
//
//  channel | ports                        | direction | payload
//  --------+------------------------------+-----------+-------------------------------
//  in      | in_valid, in_stall, in_data  | to block  | one query byte or end marker
//  out     | out_valid, out_stall, out_data | from block | one token per request
//
// One item per cycle when each item yields at most one token and out_stall stays low; an item that
// yields several tokens writes them all at once into the 4-entry result queue, which absorbs the burst.
// An accepted item passes the input register and then the result queue on its way to the output.
// Input is taken while the input register is empty or the queue has room for a full burst of three tokens.
// Reset is synchronous, active low; no clearing pass, the block is ready right after it.
// out_stall backs up only the queue; in_stall never depends on out_stall combinationally.
`timescale 1ns / 1ps
`default_nettype none

module sql_subset_tokenizer #(
  parameter int TEXT_LIMIT = sqltok_pkg::TEXT_LIMIT_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  sqltok_pkg::in_req_t  in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output sqltok_pkg::out_req_t out_data
);
  import sqltok_pkg::*;

  localparam int          OffMaxI = (TEXT_LIMIT - 1 < 65535) ? TEXT_LIMIT - 1 : 65535;
  localparam logic [15:0] OFF_MAX = 16'(OffMaxI);

  // input register
  logic    s0_vld_r;
  in_req_t s0_r;

  // lexer state
  mode_t           mode_r, mode_nxt;
  logic [15:0]     line_r, line_nxt;
  logic [15:0]     col_r, col_nxt;
  logic [15:0]     off_r, off_nxt;
  logic [15:0]     tok_start_r, tok_start_nxt;
  logic [15:0]     tok_col_r, tok_col_nxt;
  logic [15:0]     tok_len_r, tok_len_nxt;
  logic [30:0]     acc_r, acc_nxt;
  logic [7:0][7:0] wc_r;
  logic            wc_we;
  logic [2:0]      wc_idx;

  // result queue
  out_req_t              fifo_r [FQ_DEPTH];
  logic [FQ_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FQ_CNT_W-1:0]   cnt_r;
  logic                  room, fire, pop;

  // step logic
  logic [7:0]  ch;
  logic        is_digit, is_alpha, pend, do_flush, flush_vld;
  logic [15:0] col_adv, off_adv, len_inc;
  logic [34:0] prod;
  logic [3:0]  digit;
  out_req_t    pend_rec, end_rec, t0, t1;
  logic [1:0]  tn, n_res;
  out_req_t    rec [MAX_RES];

  assign room     = cnt_r <= FQ_CNT_W'(FQ_DEPTH - MAX_RES);
  assign fire     = s0_vld_r && room;
  assign in_stall = s0_vld_r && !room;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s0_r <= in_data;
    end
  end

  assign ch       = s0_r.ch;
  assign is_digit = ch inside {[8'h30:8'h39]};
  assign is_alpha = (ch inside {[8'h41:8'h5A], [8'h61:8'h7A]}) || ch == 8'h5F;
  assign col_adv  = (col_r < SAT16) ? col_r + 16'd1 : col_r;
  assign off_adv  = (off_r < OFF_MAX) ? off_r + 16'd1 : off_r;
  assign len_inc  = (tok_len_r < SAT16) ? tok_len_r + 16'd1 : tok_len_r;
  assign digit    = 4'(ch - 8'h30);
  assign prod     = {4'd0, acc_r} * 35'd10 + 35'(digit);
  assign pend     = mode_r == MODE_IDENT || mode_r == MODE_NUMBER;

  always_comb begin
    if (mode_r == MODE_NUMBER) begin
      pend_rec = mk_res(KIND_INTEGER, line_r, tok_col_r, tok_start_r, tok_len_r, acc_r,
                        ERR_NONE, 8'd0);
    end else begin
      pend_rec = mk_res(word_kind(wc_r, tok_len_r), line_r, tok_col_r, tok_start_r,
                        tok_len_r, 31'd0, ERR_NONE, 8'd0);
    end
  end

  assign end_rec = mk_res(KIND_END, line_r, col_r, off_r, 16'd0, 31'd0, ERR_NONE, 8'd0);

  always_comb begin
    mode_nxt      = mode_r;
    line_nxt      = line_r;
    col_nxt       = col_r;
    off_nxt       = off_r;
    tok_start_nxt = tok_start_r;
    tok_col_nxt   = tok_col_r;
    tok_len_nxt   = tok_len_r;
    acc_nxt       = acc_r;
    wc_we         = 1'b0;
    wc_idx        = tok_len_r[2:0];
    do_flush      = 1'b0;
    t0            = '0;
    t1            = '0;
    tn            = 2'd0;
    if (s0_r.end_of_text) begin
      if (mode_r == MODE_STRING) begin
        t0 = mk_res(KIND_INVALID, line_r, tok_col_r, tok_start_r, 16'd0, 31'd0,
                    ERR_STRING, 8'd0);
        t1 = end_rec;
        tn = 2'd2;
      end else if (mode_r != MODE_DEAD) begin
        do_flush = 1'b1;
        t0       = end_rec;
        tn       = 2'd1;
      end
      // re-arm for the next query
      mode_nxt      = MODE_IDLE;
      line_nxt      = 16'd1;
      col_nxt       = 16'd1;
      off_nxt       = 16'd0;
      tok_start_nxt = 16'd0;
      tok_col_nxt   = 16'd1;
      tok_len_nxt   = 16'd0;
      acc_nxt       = 31'd0;
    end else if (mode_r == MODE_DEAD) begin
      mode_nxt = MODE_DEAD;
    end else if (mode_r == MODE_STRING) begin
      if (ch == 8'h22) begin
        t0       = mk_res(KIND_STRING, line_r, tok_col_r, tok_start_r, tok_len_r, 31'd0,
                          ERR_NONE, 8'd0);
        tn       = 2'd1;
        mode_nxt = MODE_IDLE;
      end else begin
        tok_len_nxt = len_inc;
      end
      col_nxt = col_adv;
      off_nxt = off_adv;
    end else if (mode_r == MODE_IDENT && (is_alpha || is_digit)) begin
      wc_we       = tok_len_r < 16'd8;
      tok_len_nxt = len_inc;
      col_nxt     = col_adv;
      off_nxt     = off_adv;
    end else if (mode_r == MODE_NUMBER && is_digit) begin
      acc_nxt     = (prod > 35'(INT_MAX)) ? INT_MAX : prod[30:0];
      tok_len_nxt = len_inc;
      col_nxt     = col_adv;
      off_nxt     = off_adv;
    end else begin
      do_flush = 1'b1;
      mode_nxt = MODE_IDLE;
      case (ch)
        8'h20, 8'h09, 8'h0D: begin
          col_nxt = col_adv;
          off_nxt = off_adv;
        end
        8'h0A: begin
          line_nxt = (line_r < SAT16) ? line_r + 16'd1 : line_r;
          col_nxt  = 16'd1;
          off_nxt  = off_adv;
        end
        8'h28, 8'h29, 8'h2C, 8'h3B, 8'h3D, 8'h3C, 8'h3E, 8'h2A: begin
          t0 = mk_res(KIND_STAR, line_r, col_r, off_r, 16'd1, 31'd0, ERR_NONE, 8'd0);
          case (ch)
            8'h28:   t0.kind = KIND_LPAREN;
            8'h29:   t0.kind = KIND_RPAREN;
            8'h2C:   t0.kind = KIND_COMMA;
            8'h3B:   t0.kind = KIND_SEMI;
            8'h3D:   t0.kind = KIND_EQ;
            8'h3C:   t0.kind = KIND_LT;
            8'h3E:   t0.kind = KIND_GT;
            default: t0.kind = KIND_STAR;
          endcase
          tn      = 2'd1;
          col_nxt = col_adv;
          off_nxt = off_adv;
        end
        8'h22: begin
          // string content starts after the quote
          tok_col_nxt   = col_r;
          tok_start_nxt = off_adv;
          tok_len_nxt   = 16'd0;
          mode_nxt      = MODE_STRING;
          col_nxt       = col_adv;
          off_nxt       = off_adv;
        end
        default: begin
          if (is_digit || is_alpha) begin
            tok_col_nxt   = col_r;
            tok_start_nxt = off_r;
            tok_len_nxt   = 16'd1;
            col_nxt       = col_adv;
            off_nxt       = off_adv;
            if (is_digit) begin
              acc_nxt  = 31'(digit);
              mode_nxt = MODE_NUMBER;
            end else begin
              wc_we    = 1'b1;
              wc_idx   = 3'd0;
              mode_nxt = MODE_IDENT;
            end
          end else begin
            t0       = mk_res(KIND_INVALID, line_r, col_r, off_r, 16'd0, 31'd0,
                              ERR_CHAR, ch);
            t1       = end_rec;
            tn       = 2'd2;
            mode_nxt = MODE_DEAD;
          end
        end
      endcase
    end
  end

  assign flush_vld = do_flush && pend;
  assign n_res     = tn + {1'b0, flush_vld};

  always_comb begin
    rec[0] = flush_vld ? pend_rec : t0;
    rec[1] = flush_vld ? t0 : t1;
    rec[2] = t1;
    for (int i = 0; i < MAX_RES; i++) begin
      rec[i].last_of_run = (2'(i) == n_res - 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      line_r      <= 16'd1;
      col_r       <= 16'd1;
      off_r       <= 16'd0;
      tok_start_r <= 16'd0;
      tok_col_r   <= 16'd1;
      tok_len_r   <= 16'd0;
      acc_r       <= 31'd0;
    end else if (fire) begin
      mode_r      <= mode_nxt;
      line_r      <= line_nxt;
      col_r       <= col_nxt;
      off_r       <= off_nxt;
      tok_start_r <= tok_start_nxt;
      tok_col_r   <= tok_col_nxt;
      tok_len_r   <= tok_len_nxt;
      acc_r       <= acc_nxt;
    end
  end

  // word buffer: first eight bytes of the current identifier
  always_ff @(posedge clk) begin
    if (fire && wc_we) begin
      wc_r[wc_idx] <= ch;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < MAX_RES; i++) begin
        if (2'(i) < n_res) begin
          fifo_r[wr_ptr_r + FQ_PTR_W'(i)] <= rec[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (fire) begin
        wr_ptr_r <= wr_ptr_r + FQ_PTR_W'(n_res);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FQ_PTR_W'(1);
      end
      cnt_r <= cnt_r + (fire ? FQ_CNT_W'(n_res) : FQ_CNT_W'(0)) - FQ_CNT_W'(pop);
    end
  end

  assign out_valid = cnt_r != '0;
  assign out_data  = fifo_r[rd_ptr_r];

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FQ_CNT_W'(FQ_DEPTH))
    else $error("result queue overflow");

  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s0_r.end_of_text |=> mode_r == MODE_IDLE && line_r == 16'd1 &&
                                 col_r == 16'd1 && off_r == 16'd0)
    else $error("position not re-armed after end of text");

  a_dead_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    fire && mode_r == MODE_DEAD && !s0_r.end_of_text |-> n_res == 2'd0)
    else $error("token emitted while discarding text");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_END |-> out_data.last_of_run)
    else $error("end token not marked last of run");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s0_vld_r && cnt_r > FQ_CNT_W'(FQ_DEPTH - MAX_RES))
    else $error("input stalled without a held request");

endmodule

`default_nettype wire
